/* src/fsg_pkg.sv */
// Shared types for the falling-sand grid step core.
`default_nettype none

package fsg_pkg;

    // Operation codes carried by the func field; code 3 has no meaning.
    typedef enum logic [1:0] {
        FUNC_PLACE = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    // Move chosen for one sand cell during a sweep.
    typedef enum logic [1:0] {
        MOVE_NONE  = 2'd0,
        MOVE_DOWN  = 2'd1,
        MOVE_LEFT  = 2'd2,
        MOVE_RIGHT = 2'd3
    } t_move;

endpackage

`default_nettype wire

/* src/falling_sand_grid_step_core.sv */
// Top level of the falling-sand grid: row memory, sweep sequencer and result register.
//
//  channel | handshake          | payload                        | per item
//  --------+--------------------+--------------------------------+----------
//  in      | i_valid / o_ready  | i_func, i_cell_x, i_cell_y     | one item
//  out     | o_valid / i_ready  | o_cell_is_sand                 | one item
//
// The grid lives in one memory of GRID_H rows, GRID_W bits each, with a registered read.
// Place and read: read the row, modify/write or pick the bit, load result.
// In a tick each row pair is
// walked one cell per cycle through the cell mover, then the lower row is written back.
// After reset a clearing pass writes every row to empty, with o_ready low.
// One item is in flight at a time; a held result stalls only the load of the next one.
`default_nettype none

module falling_sand_grid_step_core
    import fsg_pkg::*;
#(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_func,
    input  wire logic [5:0] i_cell_x,
    input  wire logic [5:0] i_cell_y,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_cell_is_sand
);

    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);
    localparam logic [XW-1:0] LAST_COL = XW'(GRID_W - 1);
    localparam logic [YW-1:0] LAST_ROW = YW'(GRID_H - 1);
    localparam logic [YW-1:0] FIRST_TY = YW'(GRID_H - 2);

    typedef enum logic [2:0] {
        S_CLEAR,   // writing empty rows after reset
        S_IDLE,    // waiting for an item
        S_ACC,     // row of a place/read arrives
        S_T0,      // bottom row arrives
        S_T1,      // upper row of the pair arrives
        S_CELL,    // one cell per cycle through the mover
        S_WB,      // lower row written back
        S_DONE     // result waits for the output register
    } t_state;

    t_state r_state;

    // row memory
    logic [GRID_W-1:0] r_mem [GRID_H];
    logic [GRID_W-1:0] r_rdata;
    logic              w_we;
    logic [YW-1:0]     w_waddr;
    logic [GRID_W-1:0] w_wdata;
    logic [YW-1:0]     w_raddr;

    // item context
    t_func         r_func;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic          r_on;
    logic          r_res;

    // sweep context
    logic [GRID_W-1:0] r_cur;
    logic [GRID_W-1:0] r_below;
    logic [XW-1:0]     r_col;
    logic [YW-1:0]     r_ty;
    logic [YW-1:0]     r_clr;

    logic              r_ovalid;
    logic              r_osand;

    logic              w_in_acc;
    logic              w_on_grid;
    logic [GRID_W-1:0] w_new_cur;
    logic [GRID_W-1:0] w_new_below;
    t_move             w_move;

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_cell_is_sand = r_osand;
    assign w_in_acc       = i_valid && o_ready;
    assign w_on_grid      = (int'(i_cell_x) < GRID_W) && (int'(i_cell_y) < GRID_H);

    fsg_cell_mover #(
        .GRID_W (GRID_W)
    ) u_mover (
        .i_col   (r_col),
        .i_cur   (r_cur),
        .i_below (r_below),
        .o_cur   (w_new_cur),
        .o_below (w_new_below),
        .o_move  (w_move)
    );

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_y;
        w_wdata = r_rdata;
        w_raddr = YW'(i_cell_y);
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_IDLE: begin
                if (t_func'(i_func) == FUNC_TICK) begin
                    w_raddr = LAST_ROW;
                end
            end
            S_ACC: begin
                if (r_func == FUNC_PLACE && r_on) begin
                    w_we       = 1'b1;
                    w_waddr    = r_y;
                    w_wdata    = r_rdata;
                    w_wdata[r_x] = 1'b1;
                end
            end
            S_T0: begin
                w_raddr = FIRST_TY;
            end
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = r_ty + 1'b1;
                w_wdata = r_below;
                w_raddr = r_ty - 1'b1;
            end
            S_DONE: begin
                // the top row is still held in r_cur after the last pair
                if (r_func == FUNC_TICK) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = r_cur;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // S_DONE handles the output register itself
            if (r_ovalid && i_ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_func <= t_func'(i_func);
                        r_x    <= XW'(i_cell_x);
                        r_y    <= YW'(i_cell_y);
                        r_on   <= w_on_grid;
                        r_state <= (t_func'(i_func) == FUNC_TICK) ? S_T0 : S_ACC;
                    end
                end
                S_ACC: begin
                    r_res   <= (r_func == FUNC_READ) && r_on && r_rdata[r_x];
                    r_state <= S_DONE;
                end
                S_T0: begin
                    r_below <= r_rdata;
                    r_ty    <= FIRST_TY;
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_cur   <= r_rdata;
                    r_col   <= '0;
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_cur   <= w_new_cur;
                    r_below <= w_new_below;
                    r_col   <= r_col + 1'b1;
                    if (r_col == LAST_COL) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (r_ty == '0) begin
                        r_res   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_below <= r_cur;
                        r_ty    <= r_ty - 1'b1;
                        r_state <= S_T1;
                    end
                end
                S_DONE: begin
                    // top-row write happens on the first S_DONE cycle; mark it spent
                    r_func <= FUNC_READ;
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_osand  <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // no memory write while waiting for an item
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("row write while idle");

    // a cell step never creates or loses sand
    a_sand_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |->
            ($countones({r_cur, r_below}) == $countones({w_new_cur, w_new_below})))
        else $error("cell step changed grain count");

    // a cell that does not move leaves both rows untouched
    a_still_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL && w_move == MOVE_NONE) |->
            (w_new_cur == r_cur && w_new_below == r_below))
        else $error("rows changed without a move");

    // an accepted item always leaves idle on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted item did not start");

endmodule

`default_nettype wire

/* src/fsg_cell_mover.sv */
// Single-cell update: moves at most one sand grain from the current row into the row below.
`default_nettype none

module fsg_cell_mover
    import fsg_pkg::*;
#(
    parameter int GRID_W = 64
) (
    input  wire logic [$clog2(GRID_W)-1:0] i_col,
    input  wire logic [GRID_W-1:0]         i_cur,
    input  wire logic [GRID_W-1:0]         i_below,
    output logic      [GRID_W-1:0]         o_cur,
    output logic      [GRID_W-1:0]         o_below,
    output t_move                          o_move
);

    localparam int XW = $clog2(GRID_W);
    localparam logic [XW-1:0] LAST_COL = XW'(GRID_W - 1);

    logic [XW-1:0] w_left;
    logic [XW-1:0] w_right;
    logic          w_left_free;
    logic          w_right_free;

    assign w_left  = i_col - 1'b1;
    assign w_right = i_col + 1'b1;

    // edge columns never look past the grid
    assign w_left_free  = (i_col != '0) && !i_below[w_left];
    assign w_right_free = (i_col != LAST_COL) && !i_below[w_right];

    always_comb begin
        o_cur   = i_cur;
        o_below = i_below;
        o_move  = MOVE_NONE;
        if (i_cur[i_col]) begin
            priority if (!i_below[i_col]) begin
                o_move = MOVE_DOWN;
            end else if (w_left_free) begin
                o_move = MOVE_LEFT;
            end else if (w_right_free) begin
                o_move = MOVE_RIGHT;
            end else begin
                o_move = MOVE_NONE;
            end
        end
        unique case (o_move)
            MOVE_DOWN: begin
                o_cur[i_col]   = 1'b0;
                o_below[i_col] = 1'b1;
            end
            MOVE_LEFT: begin
                o_cur[i_col]    = 1'b0;
                o_below[w_left] = 1'b1;
            end
            MOVE_RIGHT: begin
                o_cur[i_col]     = 1'b0;
                o_below[w_right] = 1'b1;
            end
            MOVE_NONE: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the falling-sand grid step core.
`timescale 1ns / 1ps

module testbench
    import fsg_pkg::*;
();

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;

    // func code 3 has no meaning; the block must leave the grid alone and answer 0
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Longest stretch with no handshake on either side: one tick,
    // plus a full receiver stall and a full sender gap.
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_ITEMS = 75;

    localparam bit KNOWN = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] x;
        logic [5:0] y;
        logic       known;
        logic       known_val;
    } t_dir_row;

    // Directed rows. Known answers are typed in; the rest come from the grid model.
    t_dir_row dir_tab [27] = '{
        '{FUNC_READ,   6'd0,  6'd0,  KNOWN,     1'b0},  // empty after reset
        '{FUNC_READ,   6'd63, 6'd63, KNOWN,     1'b0},
        '{FUNC_UNUSED, 6'd63, 6'd63, KNOWN,     1'b0},
        '{FUNC_UNUSED, 6'd0,  6'd0,  KNOWN,     1'b0},
        '{FUNC_PLACE,  6'd63, 6'd0,  KNOWN,     1'b0},  // top right corner
        '{FUNC_PLACE,  6'd0,  6'd63, KNOWN,     1'b0},  // bottom row, never moves
        '{FUNC_READ,   6'd63, 6'd0,  PREDICTED, 1'b0},
        '{FUNC_TICK,   6'd0,  6'd0,  KNOWN,     1'b0},
        '{FUNC_READ,   6'd63, 6'd1,  PREDICTED, 1'b0},
        '{FUNC_PLACE,  6'd5,  6'd63, KNOWN,     1'b0},
        '{FUNC_PLACE,  6'd5,  6'd62, KNOWN,     1'b0},
        '{FUNC_TICK,   6'd0,  6'd0,  KNOWN,     1'b0},  // slides down-left
        '{FUNC_READ,   6'd4,  6'd63, PREDICTED, 1'b0},
        '{FUNC_PLACE,  6'd5,  6'd62, KNOWN,     1'b0},
        '{FUNC_TICK,   6'd0,  6'd0,  KNOWN,     1'b0},  // left blocked, slides right
        '{FUNC_READ,   6'd6,  6'd63, PREDICTED, 1'b0},
        '{FUNC_PLACE,  6'd5,  6'd62, KNOWN,     1'b0},
        '{FUNC_TICK,   6'd0,  6'd0,  KNOWN,     1'b0},  // all three below full: stays
        '{FUNC_READ,   6'd5,  6'd62, PREDICTED, 1'b0},
        '{FUNC_PLACE,  6'd0,  6'd62, KNOWN,     1'b0},
        '{FUNC_TICK,   6'd0,  6'd0,  KNOWN,     1'b0},  // column 0: no left try
        '{FUNC_READ,   6'd1,  6'd63, PREDICTED, 1'b0},
        '{FUNC_PLACE,  6'd63, 6'd63, KNOWN,     1'b0},
        '{FUNC_PLACE,  6'd62, 6'd63, KNOWN,     1'b0},
        '{FUNC_PLACE,  6'd63, 6'd62, KNOWN,     1'b0},
        '{FUNC_TICK,   6'd0,  6'd0,  KNOWN,     1'b0},  // last column: no right try
        '{FUNC_READ,   6'd63, 6'd62, PREDICTED, 1'b0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       drv_valid = 1'b0;
    logic [1:0] drv_func = FUNC_PLACE;
    logic [5:0] drv_x = '0;
    logic [5:0] drv_y = '0;
    logic       drv_known = 1'b0;
    logic       drv_known_val = 1'b0;
    logic       sink_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_cell_is_sand;

    // Grid model: grid_model[row] bit col, row 0 on top
    logic [GRID_W-1:0] grid_model [GRID_H];
    logic              exp_sand_q [$];
    logic              exp_sand;

    int  errors = 0;
    int  sink_stall = 0;
    int  quiet_cycles = 0;
    bit  idle_off = 1'b0;
    int  n_place = 0, n_tick = 0, n_read = 0, n_unused = 0, n_results = 0;

    falling_sand_grid_step_core #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (drv_valid),
        .o_ready       (o_ready),
        .i_func        (drv_func),
        .i_cell_x      (drv_x),
        .i_cell_y      (drv_y),
        .o_valid       (o_valid),
        .i_ready       (sink_ready),
        .o_cell_is_sand(o_cell_is_sand)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one item to the grid model and returns the answer the block owes.
    function automatic logic sand_after_item(logic [1:0] func, logic [5:0] x, logic [5:0] y);
        logic answer;
        answer = 1'b0;
        if (func == FUNC_PLACE) begin
            grid_model[y][x] = 1'b1;
        end else if (func == FUNC_READ) begin
            answer = grid_model[y][x];
        end else if (func == FUNC_TICK) begin
            // in place, bottom-up: a grain lands in a row already visited
            for (int row = GRID_H - 2; row >= 0; row--) begin
                for (int col = 0; col < GRID_W; col++) begin
                    if (grid_model[row][col]) begin
                        if (!grid_model[row+1][col]) begin
                            grid_model[row][col] = 1'b0;
                            grid_model[row+1][col] = 1'b1;
                        end else if (col > 0 && !grid_model[row+1][col-1]) begin
                            grid_model[row][col] = 1'b0;
                            grid_model[row+1][col-1] = 1'b1;
                        end else if (col < GRID_W - 1 && !grid_model[row+1][col+1]) begin
                            grid_model[row][col] = 1'b0;
                            grid_model[row+1][col+1] = 1'b1;
                        end
                    end
                end
            end
        end
        return answer;
    endfunction

    function automatic int draw_wait();
        return idle_off ? 0 : $urandom_range(0, 15);
    endfunction

    // Result check first, then the new expectation: one item in flight, so a
    // result at the edge that takes an item always belongs to an earlier one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && sink_ready) begin
                n_results++;
                if (exp_sand_q.size() == 0) begin
                    $display("%0t: result %0b with no item outstanding", $time, o_cell_is_sand);
                    errors++;
                end else begin
                    exp_sand = exp_sand_q.pop_front();
                    if (o_cell_is_sand !== exp_sand) begin
                        $display("%0t: cell_is_sand expected %0b got %0b",
                                 $time, exp_sand, o_cell_is_sand);
                        errors++;
                    end
                end
                sink_stall = draw_wait();
            end
            if (drv_valid && o_ready) begin
                exp_sand = sand_after_item(drv_func, drv_x, drv_y);
                exp_sand_q.push_back(drv_known ? drv_known_val : exp_sand);
                case (drv_func)
                    FUNC_PLACE: n_place++;
                    FUNC_TICK:  n_tick++;
                    FUNC_READ:  n_read++;
                    default:    n_unused++;
                endcase
            end
        end
    end

    // Receiver: holds ready low for the drawn number of cycles after each result
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            sink_ready <= 1'b0;
            sink_stall--;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake at all (covers the clearing pass too)
    always @(posedge i_clk) begin
        if ((drv_valid && o_ready) || (o_valid && sink_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Holds valid across items when the gap is zero; drops it otherwise.
    task automatic send_item(logic [1:0] func, logic [5:0] x, logic [5:0] y,
                             logic known, logic known_val);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            drv_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv_func      <= func;
        drv_x         <= x;
        drv_y         <= y;
        drv_known     <= known;
        drv_known_val <= known_val;
        drv_valid     <= 1'b1;
        do @(posedge i_clk); while (!(drv_valid && o_ready));
    endtask

    initial begin
        int         pick;
        logic [1:0] func;
        logic [5:0] x;
        logic [5:0] y;

        for (int row = 0; row < GRID_H; row++) grid_model[row] = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].func, dir_tab[i].x, dir_tab[i].y,
                      dir_tab[i].known, dir_tab[i].known_val);
        end

        // Random part: places cluster in a band of columns so piles form and
        // slide; reads favor the lower rows where the sand ends up.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 20 == 0) idle_off = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_ITEMS / 2) begin
                // let the block drain completely before going on
                @(negedge i_clk);
                drv_valid <= 1'b0;
                while (exp_sand_q.size() != 0) @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            x = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(20, 27)) : 6'($urandom);
            y = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(48, 63)) : 6'($urandom);
            if (pick < 45) func = FUNC_PLACE;
            else if (pick < 60) func = FUNC_TICK;
            else if (pick < 95) func = FUNC_READ;
            else func = FUNC_UNUSED;
            send_item(func, x, y, PREDICTED, 1'b0);
        end

        @(negedge i_clk);
        drv_valid <= 1'b0;
        while (exp_sand_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("items: %0d place, %0d tick, %0d read, %0d unused code; %0d results checked",
                 n_place, n_tick, n_read, n_unused, n_results);
        $display("edges, corners, slides both ways and blocked grains covered; %0d errors",
                 errors);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
src/fsg_pkg.sv
src/fsg_cell_mover.sv
src/falling_sand_grid_step_core.sv
verif/testbench.sv
